// ===== hw/rtl/line_framer_frame_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line framer frame queue
// Concurrent checks clocked on clk_i; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_FRAMER_FRAME_QUEUE_MACROS_SVH
`define LINE_FRAMER_FRAME_QUEUE_MACROS_SVH

`ifndef SYNTH
// Check that applies once reset has been released
`define LFF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that also applies while reset is held
`define LFF_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LFF_ASSERT(name, prop, msg)
`define LFF_ASSERT_RST(name, prop, msg)
`endif

`endif

// ===== hw/rtl/lff_pkg.sv =====
// ----------------------------------------------------------------------------
// lff_pkg
// Shared types and constants of the line framer frame queue.
// ----------------------------------------------------------------------------
package lff_pkg;

  localparam int unsigned LEN_W = 6;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Input item
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [7:0] capacity;
  } req_t;

  // Result item
  typedef struct packed {
    logic             ok;
    logic [7:0]       frame_byte;
    logic             last;
    logic [LEN_W-1:0] frame_length;
    logic [31:0]      dropped_count;
  } res_t;

  // Classified command held in the queue between front and back
  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_NEWLINE = 2'd1,
    CMD_POP     = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic [7:0] capacity;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

// ===== hw/rtl/lff_front.sv =====
// ----------------------------------------------------------------------------
// lff_front
// Accepts items, classifies them and queues the commands for the back end.
// ----------------------------------------------------------------------------
module lff_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lff_pkg::req_t     req_i,
  output logic              busy_o,
  output lff_pkg::cmd_chan_t cmd_o,
  input  logic              cmd_pop_i
);
  import lff_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             queue_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             accept, push, pop;
  cmd_t             cmd_new;

  // Classify: carriage returns have no effect and are not queued
  always_comb begin
    cmd_new.data     = req_i.data_byte;
    cmd_new.capacity = req_i.capacity;
    if (req_i.func == FUNC_POP) begin
      cmd_new.kind = CMD_POP;
    end else if (req_i.data_byte == CHAR_LF) begin
      cmd_new.kind = CMD_NEWLINE;
    end else begin
      cmd_new.kind = CMD_DATA;
    end
  end

  assign busy_o = (count_q == CNT_W'(DEPTH));
  assign accept = start_i && !busy_o;
  assign push   = accept && !((req_i.func == FUNC_BYTE) && (req_i.data_byte == CHAR_CR));
  assign pop    = cmd_pop_i && (count_q != '0);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_mem[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_o.valid = (count_q != '0);
  assign cmd_o.cmd   = queue_mem[rd_ptr_q];

endmodule

// ===== hw/rtl/lff_back.sv =====
// ----------------------------------------------------------------------------
// lff_back
// Line assembly, frame ring and pop streaming; one command at a time.
// ----------------------------------------------------------------------------
module lff_back #(
  parameter int unsigned QUEUE_SLOTS   = 8,
  parameter int unsigned FRAME_MAX_LEN = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lff_pkg::cmd_chan_t cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output lff_pkg::res_t      res_o
);
  import lff_pkg::*;

  localparam int unsigned SLOT_W      = $clog2(QUEUE_SLOTS);
  localparam int unsigned STORE_DEPTH = QUEUE_SLOTS * FRAME_MAX_LEN;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
  localparam logic [LEN_W-1:0]  MAX_LINE  = LEN_W'(FRAME_MAX_LEN - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_STREAM = 3'b100
  } state_e;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [LEN_W-1:0]  i);
    return ADDR_W'(s) * ADDR_W'(FRAME_MAX_LEN) + ADDR_W'(i);
  endfunction

  // Memories
  logic [7:0]       store_mem [STORE_DEPTH];
  logic [LEN_W-1:0] len_mem   [QUEUE_SLOTS];

  state_e           state_q, state_d;
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic [SLOT_W-1:0] read_slot_q, read_slot_d;
  logic [LEN_W-1:0] line_len_q, line_len_d;
  logic             disc_q, disc_d;
  logic [31:0]      drop_q, drop_d;
  logic [7:0]       cap_q, cap_d;
  logic [LEN_W-1:0] cur_len_q, cur_len_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic             res_valid_q, res_valid_d;
  logic             ok_q, ok_d;
  logic             last_q, last_d;
  logic [LEN_W-1:0] res_len_q, res_len_d;

  logic             store_we;
  logic [ADDR_W-1:0] store_wa;
  logic             len_we;
  logic [7:0]       store_rd_q;
  logic [LEN_W-1:0] len_rd_q;
  logic             is_last;
  logic             pop_fail;

  assign is_last  = ((idx_q + LEN_W'(1)) == cur_len_q);
  assign pop_fail = (read_slot_q == write_slot_q) || (len_rd_q == '0) ||
                    (cap_q <= {2'b00, len_rd_q}) || (len_rd_q > MAX_LINE);
  assign store_wa = store_addr(write_slot_q, line_len_q);

  // Command execution
  always_comb begin
    state_d      = state_q;
    write_slot_d = write_slot_q;
    read_slot_d  = read_slot_q;
    line_len_d   = line_len_q;
    disc_d       = disc_q;
    drop_d       = drop_q;
    cap_d        = cap_q;
    cur_len_d    = cur_len_q;
    idx_d        = idx_q;
    res_valid_d  = 1'b0;
    ok_d         = ok_q;
    last_d       = last_q;
    res_len_d    = res_len_q;
    cmd_pop_o    = 1'b0;
    store_we     = 1'b0;
    len_we       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.cmd.kind)
            CMD_NEWLINE: begin
              if (disc_q) begin
                disc_d = 1'b0;
              end else if (line_len_q != '0) begin
                if (next_slot(write_slot_q) == read_slot_q) begin
                  drop_d = drop_q + 32'd1;
                end else begin
                  len_we       = 1'b1;
                  write_slot_d = next_slot(write_slot_q);
                end
              end
              line_len_d = '0;
            end
            CMD_DATA: begin
              if (!disc_q) begin
                if (line_len_q >= MAX_LINE) begin
                  disc_d     = 1'b1;
                  line_len_d = '0;
                  drop_d     = drop_q + 32'd1;
                end else begin
                  store_we   = 1'b1;
                  line_len_d = line_len_q + LEN_W'(1);
                end
              end
            end
            CMD_POP: begin
              cap_d   = cmd_i.cmd.capacity;
              state_d = ST_CHECK;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      // Slot length has been read for the current head slot
      ST_CHECK: begin
        if (pop_fail) begin
          res_valid_d = 1'b1;
          ok_d        = 1'b0;
          last_d      = 1'b1;
          res_len_d   = '0;
          state_d     = ST_IDLE;
        end else begin
          cur_len_d = len_rd_q;
          idx_d     = '0;
          state_d   = ST_STREAM;
        end
      end
      // One frame byte read per cycle; its result appears in the next cycle
      ST_STREAM: begin
        res_valid_d = 1'b1;
        ok_d        = 1'b1;
        last_d      = is_last;
        res_len_d   = cur_len_q;
        idx_d       = idx_q + LEN_W'(1);
        if (is_last) begin
          read_slot_d = next_slot(read_slot_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      write_slot_q <= '0;
      read_slot_q  <= '0;
      line_len_q   <= '0;
      disc_q       <= 1'b0;
      drop_q       <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      write_slot_q <= write_slot_d;
      read_slot_q  <= read_slot_d;
      line_len_q   <= line_len_d;
      disc_q       <= disc_d;
      drop_q       <= drop_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cap_q     <= cap_d;
    cur_len_q <= cur_len_d;
    idx_q     <= idx_d;
    ok_q      <= ok_d;
    last_q    <= last_d;
    res_len_q <= res_len_d;
  end

  // Frame store: write at the line tail, registered read at the pop cursor
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_wa] <= cmd_i.cmd.data;
    end
    store_rd_q <= store_mem[store_addr(read_slot_q, idx_q)];
  end

  // Slot lengths: write on frame close, registered read at the head slot
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[write_slot_q] <= line_len_q;
    end
    len_rd_q <= len_mem[read_slot_q];
  end

  assign res_valid_o         = res_valid_q;
  assign res_o.ok            = ok_q;
  assign res_o.frame_byte    = ok_q ? store_rd_q : 8'h00;
  assign res_o.last          = last_q;
  assign res_o.frame_length  = res_len_q;
  assign res_o.dropped_count = drop_q;

endmodule

// ===== hw/rtl/line_framer_frame_queue.sv =====
// ----------------------------------------------------------------------------
// line_framer_frame_queue
// Newline-delimited frame queue: assembles received bytes into frames and
// streams the oldest frame on request.
// ----------------------------------------------------------------------------
//   Items are offered on req_i with start_i; one is taken at a clock edge where
//   start_i is high and busy_o is low. func 0 feeds a received byte, func 1
//   pops the oldest frame. busy_o rises only when the four-entry command queue
//   between front and back is full. Byte items give no result and are handled
//   in the back end's idle state; carriage returns are discarded at the front.
//   An item reaches the back end the cycle after it is taken if the back end
//   is idle. A pop then passes to a check state on the registered slot length
//   lookup; a failing pop gives one registered result from it, and a good pop
//   streams its frame one byte per cycle from the registered frame store read,
//   holding the back end from the pop until the last byte is streamed.
//   Results appear on res_o for exactly one cycle, marked by res_valid_o; the
//   receiver cannot stall them.
//   Reset clears the ring pointers, the line state, the drop counter and the
//   command queue; frame store contents are undefined until written.
// ----------------------------------------------------------------------------
`include "line_framer_frame_queue_macros.svh"

module line_framer_frame_queue #(
  parameter int unsigned QUEUE_SLOTS   = 8,
  parameter int unsigned FRAME_MAX_LEN = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lff_pkg::req_t req_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output lff_pkg::res_t res_o
);
  import lff_pkg::*;

  cmd_chan_t cmd_chan;
  logic      cmd_pop;

  // Front: accept and classify
  lff_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .req_i     (req_i),
    .busy_o    (busy_o),
    .cmd_o     (cmd_chan),
    .cmd_pop_i (cmd_pop)
  );

  // Back: execute commands against the frame ring
  lff_back #(
    .QUEUE_SLOTS   (QUEUE_SLOTS),
    .FRAME_MAX_LEN (FRAME_MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_chan),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Checks
  `LFF_ASSERT(a_pop_needs_head, cmd_pop |-> cmd_chan.valid, "command taken from empty queue")
  `LFF_ASSERT(a_frame_continues, res_valid_o && res_o.ok && !res_o.last |=> res_valid_o, "frame stream broken")
  `LFF_ASSERT(a_frame_len_stable, res_valid_o && res_o.ok && !res_o.last |=> res_o.frame_length == $past(res_o.frame_length), "frame length changed mid-frame")
  `LFF_ASSERT(a_fail_fields, res_valid_o && !res_o.ok |-> res_o.last && (res_o.frame_byte == 8'h00) && (res_o.frame_length == '0), "bad failure result")
  `LFF_ASSERT_RST(a_quiet_in_reset, !rst_ni |-> !res_valid_o, "result during reset")

endmodule
